/* sv/sha_pkg.sv */
package sha_pkg;

    localparam int WordW  = 32;
    localparam int CountW = 61;
    localparam int BlkWords = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    localparam logic [31:0] HashInit [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391050b4, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

/* sv/sha_stream_if.sv */
interface sha_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* sv/sha256_stream_hasher.sv */
// SHA-256 stream hasher.
// in_ch carries words of {op, data}: op 0 absorbs one message byte, op 1
// finishes the message. out_ch carries eight digest words per finish, most
// significant first, each with its word_index; last_word marks the eighth.
// An absorb word is taken while in_ch is ready; the 64th byte of a block
// starts a compression (load, 64 rounds on one round unit, add) during
// which in_ch is not ready. A finish pads from the partially filled word up
// to word 15, then runs one compression; when 56 or more bytes are pending
// a second padding block and a second compression follow. It then emits
// one digest word per cycle while the receiver takes them.
// The message schedule sits in a 16-word RAM with a registered read.
// A stalled receiver holds the output register and pauses the emit; no
// input is taken until all eight words have been delivered.
// Reset (rst_n low, asynchronous) loads the initial hash values and clears
// the byte count; after a finish the same values are restored.
module sha256_stream_hasher (
    input  logic         clk,
    input  logic         rst_n,
    sha_stream_if.sink   in_ch,
    sha_stream_if.source out_ch
);
    import sha_pkg::*;

    sha_core u_core (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
    );
endmodule

/* sv/sha_ram.sv */
module sha_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* sv/sha_core.sv */
module sha_core (
    input  logic                clk,
    input  logic                rst_n,
    sha_stream_if.sink          in_ch,
    sha_stream_if.source        out_ch
);
    import sha_pkg::*;

    state_t state_reg, state_next;
    logic [CountW-1:0] count_reg, count_next;
    logic [31:0] word_acc_reg, word_acc_next;
    logic [31:0] hv_reg [8];
    logic [31:0] hv_next [8];
    logic [31:0] wv_reg [8];
    logic [31:0] wv_next [8];
    logic [5:0]  rnd_reg, rnd_next;
    logic [3:0]  pad_idx_reg, pad_idx_next;
    logic        pad_two_reg, pad_two_next;
    logic        pad_first_reg, pad_first_next;
    logic        fin_reg, fin_next;
    logic [2:0]  emit_reg, emit_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg, out_next;

    // message schedule memory: 16 words, one write and one read per cycle
    logic        we;
    logic [3:0]  waddr, raddr;
    logic [31:0] wdata, rdata;
    // window taps beyond the memory read are kept in a small register ring
    logic [31:0] win_reg [16];
    logic [31:0] win_next [16];

    sha_ram #(.Width(32), .Depth(16)) u_wram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic [31:0] sched_w, t1, t2, ew, pad_word;
    logic [63:0] bitlen;

    assign bitlen = {count_reg, 3'b000};

    // padding word for slot pad_idx of a padding block
    always_comb
    begin
        logic [5:0]  fill;
        logic [31:0] w;
        logic [5:0]  base;
        fill = count_reg[5:0];
        base = {pad_idx_reg, 2'b00};
        w = 32'h0;
        for (int b = 0; b < 4; b++)
        begin
            logic [5:0] p;
            logic [7:0] v;
            p = base + 6'(b);
            v = 8'h00;
            if (pad_first_reg && (p < fill))
            begin
                v = 8'h00;
            end
            else if (pad_first_reg && (p == fill))
            begin
                v = 8'h80;
            end
            if (!pad_two_reg || !pad_first_reg)
            begin
                if (p >= 6'd56)
                begin
                    v = bitlen[63 - 8 * (p - 56) -: 8];
                end
            end
            w[31 - 8 * b -: 8] = v;
        end
        pad_word = w;
    end

    // schedule expansion for rounds 16 and later
    always_comb
    begin
        logic [31:0] x2, x15, x7, x16, s0, s1;
        x2  = win_reg[4'(rnd_reg - 6'd2)];
        x15 = win_reg[4'(rnd_reg - 6'd15)];
        x7  = win_reg[4'(rnd_reg - 6'd7)];
        x16 = win_reg[rnd_reg[3:0]];
        s1 = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
        s0 = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
        sched_w = s1 + x7 + s0 + x16;
    end

    assign ew = (rnd_reg < 6'd16) ? rdata : sched_w;

    always_comb
    begin
        t1 = wv_reg[7] + (rotr(wv_reg[4], 6) ^ rotr(wv_reg[4], 11) ^ rotr(wv_reg[4], 25))
           + ((wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6])) + RoundK[rnd_reg] + ew;
        t2 = (rotr(wv_reg[0], 2) ^ rotr(wv_reg[0], 13) ^ rotr(wv_reg[0], 22))
           + ((wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]));
    end

    assign in_ch.ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.payload = out_reg;

    // next state and datapath control
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        word_acc_next = word_acc_reg;
        hv_next = hv_reg;
        wv_next = wv_reg;
        win_next = win_reg;
        rnd_next = rnd_reg;
        pad_idx_next = pad_idx_reg;
        pad_two_next = pad_two_reg;
        pad_first_next = pad_first_reg;
        fin_next = fin_reg;
        emit_next = emit_reg;
        out_valid_next = out_valid_reg;
        out_next = out_reg;
        we = 1'b0;
        waddr = 4'(count_reg[5:2]);
        wdata = word_acc_next;
        raddr = 4'd0;
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    if (!in_ch.payload.op)
                    begin
                        word_acc_next = {word_acc_reg[23:0], in_ch.payload.data};
                        count_next = count_reg + 1'b1;
                        if (count_reg[1:0] == 2'd3)
                        begin
                            we = 1'b1;
                            waddr = count_reg[5:2];
                            wdata = word_acc_next;
                        end
                        if (count_reg[5:0] == 6'd63)
                        begin
                            fin_next = 1'b0;
                            state_next = ST_LOAD;
                        end
                    end
                    else
                    begin
                        pad_first_next = 1'b1;
                        pad_two_next = (count_reg[5:0] >= 6'd56);
                        pad_idx_next = count_reg[5:2];
                        fin_next = 1'b1;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                // the first partial word keeps its buffered bytes
                we = 1'b1;
                waddr = pad_idx_reg;
                wdata = pad_word;
                if (pad_first_reg && (pad_idx_reg == count_reg[5:2]))
                begin
                    case (count_reg[1:0])
                        2'd1: wdata = {word_acc_reg[7:0], pad_word[23:0]};
                        2'd2: wdata = {word_acc_reg[15:0], pad_word[15:0]};
                        2'd3: wdata = {word_acc_reg[23:0], pad_word[7:0]};
                        default: wdata = pad_word;
                    endcase
                end
                pad_idx_next = pad_idx_reg + 4'd1;
                if (pad_idx_reg == 4'd15)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                wv_next = hv_reg;
                rnd_next = 6'd0;
                raddr = 4'd0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                raddr = 4'(rnd_reg[3:0] + 4'd1);
                win_next[rnd_reg[3:0]] = ew;
                wv_next[7] = wv_reg[6];
                wv_next[6] = wv_reg[5];
                wv_next[5] = wv_reg[4];
                wv_next[4] = wv_reg[3] + t1;
                wv_next[3] = wv_reg[2];
                wv_next[2] = wv_reg[1];
                wv_next[1] = wv_reg[0];
                wv_next[0] = t1 + t2;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hv_next[i] = hv_reg[i] + wv_reg[i];
                end
                if (!fin_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (pad_first_reg && pad_two_reg)
                begin
                    pad_first_next = 1'b0;
                    pad_idx_next = 4'd0;
                    state_next = ST_PAD;
                end
                else
                begin
                    emit_next = 3'd0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_next.digest_word = hv_reg[emit_reg];
                    out_next.word_index = emit_reg;
                    out_next.last_word = (emit_reg == 3'd7);
                    emit_next = emit_reg + 3'd1;
                    if (emit_reg == 3'd7)
                    begin
                        hv_next = HashInit;
                        count_next = '0;
                        fin_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            hv_reg <= HashInit;
            rnd_reg <= '0;
            pad_idx_reg <= '0;
            pad_two_reg <= 1'b0;
            pad_first_reg <= 1'b0;
            fin_reg <= 1'b0;
            emit_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            hv_reg <= hv_next;
            rnd_reg <= rnd_next;
            pad_idx_reg <= pad_idx_next;
            pad_two_reg <= pad_two_next;
            pad_first_reg <= pad_first_next;
            fin_reg <= fin_next;
            emit_reg <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        word_acc_reg <= word_acc_next;
        wv_reg <= wv_next;
        win_reg <= win_next;
        out_reg <= out_next;
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && rnd_reg == 6'd63) |=> state_reg == ST_ADD)
        else $error("round count slip");
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.last_word == (out_reg.word_index == 3'd7)))
        else $error("last flag wrong");
endmodule
